FILE: design/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared constants, types and codes of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int MAX_SYMBOLS = 32;
    localparam int NODE_SLOTS  = 2 * MAX_SYMBOLS - 1;
    localparam int ID_W        = $clog2(NODE_SLOTS);
    localparam int LEAF_AW     = $clog2(MAX_SYMBOLS);
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int IN_WEIGHT_W = 16;
    localparam int WEIGHT_W    = IN_WEIGHT_W + $clog2(MAX_SYMBOLS);
    localparam int LEN_W       = $clog2(MAX_SYMBOLS);
    localparam int SYM_W       = 8;
    localparam int CODE_W      = 31;
    localparam int OUT_LEN_W   = 5;
    localparam int MAX_OUT_LEN = 31;

    typedef enum logic [1:0] {
        PQ_HOLD,
        PQ_INSERT,
        PQ_POP,
        PQ_CLEAR
    } pq_op_t;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP
    } stk_op_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_POP_A,
        S_POP_B,
        S_MERGE,
        S_FETCH,
        S_DECIDE
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [WEIGHT_W-1:0] weight;
        logic [ID_W-1:0]     id;
    } pq_entry_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   node;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } stk_entry_t;

endpackage

FILE: design/hcb_ram.sv
// ----------------------------------------------------------------------------
// hcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/hcb_pq_cell.sv
// ----------------------------------------------------------------------------
// hcb_pq_cell
// One cell of the sorted node queue: holds one node, lightest at cell zero.
// ----------------------------------------------------------------------------
module hcb_pq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  hcb_pkg::pq_op_t   op,
    input  hcb_pkg::pq_entry_t new_entry,
    input  hcb_pkg::pq_entry_t prev_entry,
    input  logic              prev_lt,
    input  hcb_pkg::pq_entry_t next_entry,
    output hcb_pkg::pq_entry_t entry,
    output logic              lt
);

    logic               valid_reg, valid_next;
    hcb_pkg::pq_entry_t data_reg, data_next;

    // new node sorts ahead of this one: lower weight, lower id on a tie
    assign lt = !valid_reg ||
                ({new_entry.weight, new_entry.id} < {data_reg.weight, data_reg.id});

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (op)
            hcb_pkg::PQ_INSERT:
            begin
                if (lt)
                begin
                    if (prev_lt)
                    begin
                        data_next  = prev_entry;
                        valid_next = prev_entry.valid;
                    end
                    else
                    begin
                        data_next  = new_entry;
                        valid_next = 1'b1;
                    end
                end
            end
            hcb_pkg::PQ_POP:
            begin
                data_next  = next_entry;
                valid_next = next_entry.valid;
            end
            hcb_pkg::PQ_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        entry       = data_reg;
        entry.valid = valid_reg;
    end

endmodule

FILE: design/hcb_stk_cell.sv
// ----------------------------------------------------------------------------
// hcb_stk_cell
// One cell of the walk stack: push shifts away from the top, pop toward it.
// ----------------------------------------------------------------------------
module hcb_stk_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  hcb_pkg::stk_op_t    op,
    input  hcb_pkg::stk_entry_t push_in,
    input  hcb_pkg::stk_entry_t pop_in,
    output hcb_pkg::stk_entry_t entry
);

    logic                valid_reg, valid_next;
    hcb_pkg::stk_entry_t data_reg, data_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (op)
            hcb_pkg::STK_PUSH:
            begin
                data_next  = push_in;
                valid_next = push_in.valid;
            end
            hcb_pkg::STK_POP:
            begin
                data_next  = pop_in;
                valid_next = pop_in.valid;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        entry       = data_reg;
        entry.valid = valid_reg;
    end

endmodule

FILE: design/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_builder
// Builds Huffman codes from a set of symbol/weight pairs and streams them out.
// ----------------------------------------------------------------------------
// Symbols load at one per cycle into a chain of sorted queue cells; the
// transaction with tlast closes the set (items beyond MAX_SYMBOLS are dropped).
// For n loaded symbols the block then runs n-1 merges (pop, pop, sorted
// insert into the cell chain), followed by a preorder tree walk of the
// 2n-1 tree nodes, a fetch state and a decide state per node, through the
// registered child and symbol RAMs; an output stall holds the walk.
// Input tready is low from the closing transaction until the last code has
// been loaded into the output register.
module huffman_code_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // symbol[7:0], weight[23:8]
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_symbol[7:0], code_bits[38:8],
                                        // code_length[43:39], zero[47:44]
    output logic        m_axis_tlast    // out_last
);

    localparam int N = hcb_pkg::MAX_SYMBOLS;

    hcb_pkg::state_t state_reg, state_next;

    logic [hcb_pkg::CNT_W-1:0]    leaf_count_reg, leaf_count_next;
    logic [hcb_pkg::CNT_W-1:0]    merges_reg, merges_next;
    logic [hcb_pkg::ID_W-1:0]     made_reg, made_next;
    logic [hcb_pkg::ID_W-1:0]     a_id_reg, a_id_next;
    logic [hcb_pkg::WEIGHT_W-1:0] a_w_reg, a_w_next;
    logic [hcb_pkg::ID_W-1:0]     b_id_reg, b_id_next;
    logic [hcb_pkg::WEIGHT_W-1:0] b_w_reg, b_w_next;
    logic [hcb_pkg::ID_W-1:0]     cur_reg, cur_next;
    logic [hcb_pkg::CODE_W-1:0]   code_reg, code_next;
    logic [hcb_pkg::LEN_W-1:0]    len_reg, len_next;

    logic                          out_valid_reg, out_valid_next;
    logic [hcb_pkg::SYM_W-1:0]     out_sym_reg, out_sym_next;
    logic [hcb_pkg::CODE_W-1:0]    out_code_reg, out_code_next;
    logic [hcb_pkg::OUT_LEN_W-1:0] out_len_reg, out_len_next;
    logic                          out_last_reg, out_last_next;

    hcb_pkg::pq_op_t     pq_op;
    hcb_pkg::pq_entry_t  pq_new;
    hcb_pkg::pq_entry_t  pq_q   [N];
    logic                pq_lt  [N];
    hcb_pkg::stk_op_t    stk_op;
    hcb_pkg::stk_entry_t stk_new;
    hcb_pkg::stk_entry_t stk_q  [N];

    localparam hcb_pkg::pq_entry_t  PQ_EMPTY  = '0;
    localparam hcb_pkg::stk_entry_t STK_EMPTY = '0;

    logic                         sym_we;
    logic [hcb_pkg::LEAF_AW-1:0]  sym_waddr, sym_raddr;
    logic [hcb_pkg::SYM_W-1:0]    sym_rdata;
    logic                         child_we;
    logic [hcb_pkg::LEAF_AW-1:0]  child_waddr, child_raddr;
    logic [2*hcb_pkg::ID_W-1:0]   child_rdata;
    logic [hcb_pkg::ID_W-1:0]     inner_idx;

    logic                          in_accept;
    logic                          room;
    logic                          is_leaf;
    logic                          can_emit;
    logic [hcb_pkg::WEIGHT_W-1:0]  sum_w;
    logic [hcb_pkg::CODE_W-1:0]    code_shift;
    logic [hcb_pkg::LEN_W+4:0]     len_wide;
    logic [hcb_pkg::OUT_LEN_W-1:0] len_sat;

    // ---- node queue chain ----
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_pq
            hcb_pq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (pq_op),
                .new_entry  (pq_new),
                .prev_entry ((gi == 0) ? PQ_EMPTY : pq_q[(gi == 0) ? 0 : gi - 1]),
                .prev_lt    ((gi == 0) ? 1'b0 : pq_lt[(gi == 0) ? 0 : gi - 1]),
                .next_entry ((gi == N - 1) ? PQ_EMPTY : pq_q[(gi == N - 1) ? gi : gi + 1]),
                .entry      (pq_q[gi]),
                .lt         (pq_lt[gi])
            );
        end
    endgenerate

    // ---- walk stack chain ----
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_stk
            hcb_stk_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .op      (stk_op),
                .push_in ((gi == 0) ? stk_new : stk_q[(gi == 0) ? 0 : gi - 1]),
                .pop_in  ((gi == N - 1) ? STK_EMPTY : stk_q[(gi == N - 1) ? gi : gi + 1]),
                .entry   (stk_q[gi])
            );
        end
    endgenerate

    hcb_ram #(
        .WIDTH (hcb_pkg::SYM_W),
        .DEPTH (N)
    ) u_sym_ram (
        .clk   (clk),
        .we    (sym_we),
        .waddr (sym_waddr),
        .wdata (s_axis_tdata[7:0]),
        .raddr (sym_raddr),
        .rdata (sym_rdata)
    );

    hcb_ram #(
        .WIDTH (2 * hcb_pkg::ID_W),
        .DEPTH (N)
    ) u_child_ram (
        .clk   (clk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata ({a_id_reg, b_id_reg}),
        .raddr (child_raddr),
        .rdata (child_rdata)
    );

    assign s_axis_tready = (state_reg == hcb_pkg::S_LOAD);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign room          = (leaf_count_reg < hcb_pkg::CNT_W'(N));
    assign sym_we        = in_accept && room;
    assign sym_waddr     = leaf_count_reg[hcb_pkg::LEAF_AW-1:0];
    assign sym_raddr     = cur_reg[hcb_pkg::LEAF_AW-1:0];
    assign inner_idx     = cur_reg - hcb_pkg::ID_W'(leaf_count_reg);
    assign child_raddr   = inner_idx[hcb_pkg::LEAF_AW-1:0];
    assign child_waddr   = merges_reg[hcb_pkg::LEAF_AW-1:0];
    assign child_we      = (state_reg == hcb_pkg::S_MERGE);
    assign is_leaf       = (cur_reg < hcb_pkg::ID_W'(leaf_count_reg));
    assign can_emit      = !out_valid_reg || m_axis_tready;
    assign sum_w         = a_w_reg + b_w_reg;
    assign code_shift    = {code_reg[hcb_pkg::CODE_W-2:0], 1'b0};
    assign len_wide      = {5'd0, len_reg};
    assign len_sat       = (len_wide > (hcb_pkg::LEN_W + 5)'(hcb_pkg::MAX_OUT_LEN)) ?
                           hcb_pkg::OUT_LEN_W'(hcb_pkg::MAX_OUT_LEN) :
                           len_wide[hcb_pkg::OUT_LEN_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        leaf_count_next = leaf_count_reg;
        merges_next     = merges_reg;
        made_next       = made_reg;
        a_id_next       = a_id_reg;
        a_w_next        = a_w_reg;
        b_id_next       = b_id_reg;
        b_w_next        = b_w_reg;
        cur_next        = cur_reg;
        code_next       = code_reg;
        len_next        = len_reg;
        out_valid_next  = m_axis_tready ? 1'b0 : out_valid_reg;
        out_sym_next    = out_sym_reg;
        out_code_next   = out_code_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        pq_op           = hcb_pkg::PQ_HOLD;
        pq_new          = PQ_EMPTY;
        stk_op          = hcb_pkg::STK_HOLD;
        stk_new         = STK_EMPTY;

        unique case (state_reg)
            hcb_pkg::S_LOAD:
            begin
                pq_new.valid  = 1'b1;
                pq_new.weight = hcb_pkg::WEIGHT_W'(s_axis_tdata[23:8]);
                pq_new.id     = hcb_pkg::ID_W'(leaf_count_reg);
                if (in_accept)
                begin
                    if (room)
                    begin
                        pq_op           = hcb_pkg::PQ_INSERT;
                        leaf_count_next = leaf_count_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        made_next   = hcb_pkg::ID_W'(leaf_count_next);
                        merges_next = '0;
                        state_next  = hcb_pkg::S_POP_A;
                    end
                end
            end
            hcb_pkg::S_POP_A:
            begin
                if ((merges_reg + 1'b1) < leaf_count_reg)
                begin
                    a_id_next  = pq_q[0].id;
                    a_w_next   = pq_q[0].weight;
                    pq_op      = hcb_pkg::PQ_POP;
                    state_next = hcb_pkg::S_POP_B;
                end
                else
                begin
                    cur_next   = made_reg - 1'b1;
                    code_next  = '0;
                    len_next   = '0;
                    state_next = hcb_pkg::S_FETCH;
                end
            end
            hcb_pkg::S_POP_B:
            begin
                b_id_next  = pq_q[0].id;
                b_w_next   = pq_q[0].weight;
                pq_op      = hcb_pkg::PQ_POP;
                state_next = hcb_pkg::S_MERGE;
            end
            hcb_pkg::S_MERGE:
            begin
                pq_new.valid  = 1'b1;
                pq_new.weight = sum_w;
                pq_new.id     = made_reg;
                pq_op         = hcb_pkg::PQ_INSERT;
                made_next     = made_reg + 1'b1;
                merges_next   = merges_reg + 1'b1;
                state_next    = hcb_pkg::S_POP_A;
            end
            hcb_pkg::S_FETCH:
            begin
                state_next = hcb_pkg::S_DECIDE;
            end
            hcb_pkg::S_DECIDE:
            begin
                if (!is_leaf)
                begin
                    // descend left, park the right child on the stack
                    stk_new.valid = 1'b1;
                    stk_new.node  = child_rdata[hcb_pkg::ID_W-1:0];
                    stk_new.code  = code_shift | hcb_pkg::CODE_W'(1);
                    stk_new.len   = len_reg + 1'b1;
                    stk_op        = hcb_pkg::STK_PUSH;
                    cur_next      = child_rdata[2*hcb_pkg::ID_W-1:hcb_pkg::ID_W];
                    code_next     = code_shift;
                    len_next      = len_reg + 1'b1;
                    state_next    = hcb_pkg::S_FETCH;
                end
                else if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next   = sym_rdata;
                    out_code_next  = code_reg;
                    out_len_next   = len_sat;
                    out_last_next  = !stk_q[0].valid;
                    if (stk_q[0].valid)
                    begin
                        stk_op     = hcb_pkg::STK_POP;
                        cur_next   = stk_q[0].node;
                        code_next  = stk_q[0].code;
                        len_next   = stk_q[0].len;
                        state_next = hcb_pkg::S_FETCH;
                    end
                    else
                    begin
                        pq_op           = hcb_pkg::PQ_CLEAR;
                        leaf_count_next = '0;
                        state_next      = hcb_pkg::S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = hcb_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hcb_pkg::S_LOAD;
            leaf_count_reg <= '0;
            merges_reg     <= '0;
            made_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            leaf_count_reg <= leaf_count_next;
            merges_reg     <= merges_next;
            made_reg       <= made_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_id_reg     <= a_id_next;
        a_w_reg      <= a_w_next;
        b_id_reg     <= b_id_next;
        b_w_reg      <= b_w_next;
        cur_reg      <= cur_next;
        code_reg     <= code_next;
        len_reg      <= len_next;
        out_sym_reg  <= out_sym_next;
        out_code_reg <= out_code_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_len_reg, out_code_reg, out_sym_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: design/hcb_checker.sv
// ----------------------------------------------------------------------------
// hcb_checker
// Port-level checks of the Huffman code builder, bound to the top level.
// ----------------------------------------------------------------------------
module hcb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled output transaction holds
    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // closing transaction starts the build, no input until the codes are out
    a_close_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input accepted right after closing transaction");

    // zero-length code carries no bits
    a_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[43:39] == 5'd0) |-> (m_axis_tdata[38:8] == 31'd0))
        else $error("zero-length code with bits set");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/huffman_code_builder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_code_builder_tb
// Streams symbol sets into the Huffman code builder and checks every code.
// ----------------------------------------------------------------------------
// Sets of symbol/weight pairs are queued by an initial block and driven with
// random gaps; a clocked monitor with random back-pressure compares each code
// against a tree built in the bench on every closing transaction.
module huffman_code_builder_tb;

    typedef struct {
        logic [7:0]  symbol;
        logic [15:0] weight;
        logic        last;
    } sym_item_t;

    typedef struct {
        logic [7:0]  symbol;
        logic [30:0] code;
        logic [4:0]  length;
        logic        last;
    } code_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    sym_item_t  pending_syms[$];
    code_item_t expected_codes[$];
    int         error_count;
    bit         stimulus_done;

    // bench copy of the tree state
    logic [7:0]  set_symbols[hcb_pkg::MAX_SYMBOLS];
    logic [31:0] set_weights[hcb_pkg::NODE_SLOTS];
    bit          set_live[hcb_pkg::NODE_SLOTS];
    int          set_left[hcb_pkg::MAX_SYMBOLS];
    int          set_right[hcb_pkg::MAX_SYMBOLS];
    int          set_count;

    huffman_code_builder DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic int pop_lightest(input int made);
        int best;
        best = -1;
        for (int i = 0; i < made; i++)
            if (set_live[i] && (best < 0 || set_weights[i] < set_weights[best]))
                best = i;
        set_live[best] = 0;
        return best;
    endfunction

    // Store a leaf; on the closing transaction build the tree and queue codes.
    task automatic predict_codes(input sym_item_t it);
        int made, a, b, sp, nd, len;
        int stk_node[hcb_pkg::NODE_SLOTS];
        logic [30:0] stk_code[hcb_pkg::NODE_SLOTS];
        int stk_len[hcb_pkg::NODE_SLOTS];
        logic [30:0] code;
        code_item_t c;
        if (set_count < hcb_pkg::MAX_SYMBOLS)
        begin
            set_symbols[set_count] = it.symbol;
            set_weights[set_count] = it.weight;
            set_live[set_count] = 1;
            set_count++;
        end
        if (!it.last)
            return;
        made = set_count;
        for (int m = 0; m + 1 < set_count; m++)
        begin
            a = pop_lightest(made);
            b = pop_lightest(made);
            set_weights[made] = set_weights[a] + set_weights[b];
            set_live[made] = 1;
            set_left[m] = a;
            set_right[m] = b;
            made++;
        end
        stk_node[0] = made - 1;
        stk_code[0] = '0;
        stk_len[0] = 0;
        sp = 1;
        while (sp > 0)
        begin
            sp--;
            nd = stk_node[sp];
            code = stk_code[sp];
            len = stk_len[sp];
            if (nd < set_count)
            begin
                c.symbol = set_symbols[nd];
                c.code = code;
                c.length = (len > 31) ? 5'd31 : len[4:0];
                c.last = 0;
                expected_codes.push_back(c);
            end
            else
            begin
                stk_node[sp] = set_right[nd - set_count];
                stk_code[sp] = {code[29:0], 1'b1};
                stk_len[sp] = len + 1;
                sp++;
                stk_node[sp] = set_left[nd - set_count];
                stk_code[sp] = {code[29:0], 1'b0};
                stk_len[sp] = len + 1;
                sp++;
            end
        end
        expected_codes[$].last = 1;
        set_count = 0;
        for (int i = 0; i < hcb_pkg::NODE_SLOTS; i++)
            set_live[i] = 0;
    endtask

    task automatic queue_set(input int n, input int wmode);
        sym_item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.symbol = $urandom;
            case (wmode)
                0: it.weight = $urandom;
                1: it.weight = $urandom_range(0, 3);
                2: it.weight = 16'hFFFF;
                3: it.weight = 16'd1 << (i % 16);
                default: it.weight = (i == 0) ? 16'd0 : 16'hFFFF;
            endcase
            it.last = (i == n - 1);
            pending_syms.push_back(it);
        end
    endtask

    // driver: gap drawn per item, valid held across back-to-back items
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
            send_gap = $urandom_range(0, 16);
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_codes(pending_syms.pop_front());
                send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            end
            if (s_axis_tvalid && !s_axis_tready)
                ;
            else if (send_gap > 0 || pending_syms.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {pending_syms[0].weight, pending_syms[0].symbol};
                s_axis_tlast <= pending_syms[0].last;
            end
        end
    end

    // monitor with random stalls
    int stall;
    always @(posedge clk or negedge rst_n)
    begin
        code_item_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_codes.size() == 0)
                    report_mismatch("unexpected code", m_axis_tdata, '0);
                else
                begin
                    want = expected_codes.pop_front();
                    if (m_axis_tdata[7:0] !== want.symbol)
                        report_mismatch("symbol", m_axis_tdata[7:0], want.symbol);
                    if (m_axis_tdata[38:8] !== want.code)
                        report_mismatch("code", m_axis_tdata[38:8], want.code);
                    if (m_axis_tdata[43:39] !== want.length)
                        report_mismatch("length", m_axis_tdata[43:39], want.length);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", m_axis_tlast, want.last);
                end
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        sym_item_t it;
        error_count = 0;
        stimulus_done = 0;
        set_count = 0;
        for (int i = 0; i < hcb_pkg::NODE_SLOTS; i++)
            set_live[i] = 0;
        rst_n = 1'b0;
        // directed: single symbol, pair, equal and extreme weights, overflow
        it.symbol = 8'hFF; it.weight = 16'hFFFF; it.last = 1;
        pending_syms.push_back(it);
        it.symbol = 8'h00; it.weight = 16'h0000; it.last = 1;
        pending_syms.push_back(it);
        queue_set(2, 4);
        queue_set(3, 2);
        queue_set(17, 3);
        queue_set(hcb_pkg::MAX_SYMBOLS + 2, 1);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_syms.size() > 380)
            @(posedge clk);
        // random sets, mostly small, a few near full, full or overfull
        for (int total = 0; total < 400;)
        begin
            int n;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36)
                                            : $urandom_range(1, 8);
            queue_set(n, $urandom_range(0, 4));
            total += n;
        end
        while (pending_syms.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_codes.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
